### design/prdg_pkg.sv
package prdg_pkg;

    localparam int MAX_DIM        = 4096;
    localparam int COEF_FRAC_BITS = 24;
    localparam int NDC_FRAC_BITS  = 30;
    localparam int COEF_SLOTS     = 25;
    localparam int VIEW_BASE      = 16;

    // divider: one stage for the integer bit, then DIV_STEPS quotient bits per stage
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = 30 / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    // square root: SQ_STEPS result bits per stage
    localparam int SQ_STEPS  = 4;
    localparam int SQ_STAGES = 32 / SQ_STEPS;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic        vld;
        logic [23:0] pix;
        logic        nxn;
        logic        nyn;
        logic [2:0]  neg;
        logic        deg;
    } side_t;

endpackage

### design/prdg_in_if.sv
interface prdg_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;

    modport source (output valid, cmd, coef_index, coef_value, pixel_x, pixel_y,
                    input ready);
    modport sink (input valid, cmd, coef_index, coef_value, pixel_x, pixel_y,
                  output ready);
endinterface

### design/prdg_out_if.sv
interface prdg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [23:0]        pixel_index;
    logic               degenerate;

    modport source (output valid, dir_x, dir_y, dir_z, pixel_index, degenerate,
                    input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, pixel_index, degenerate,
                  output ready);
endinterface

### design/prdg_div.sv
module prdg_div
    import prdg_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] num,
    input  logic [32:0] den,
    output logic [30:0] quo
);

    // quo = floor(num * 2^30 / den), num <= den
    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] den;
        logic [30:0] quo;
    } div_st_t;

    div_st_t st_reg  [DIV_LAT];
    div_st_t st_next [DIV_LAT];

    function automatic div_st_t div_iter(input div_st_t s);
        div_st_t     r;
        logic [33:0] t;
        r = s;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r.rem, 1'b0};
            if (t >= {1'b0, r.den})
            begin
                t     = t - {1'b0, r.den};
                r.quo = {r.quo[29:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[29:0], 1'b0};
            end
            r.rem = t[32:0];
        end
        return r;
    endfunction

    always_comb
    begin
        st_next[0].den = den;
        if ({2'b00, num} >= den)
        begin
            st_next[0].rem = {2'b00, num} - den;
            st_next[0].quo = 31'd1;
        end
        else
        begin
            st_next[0].rem = {2'b00, num};
            st_next[0].quo = 31'd0;
        end
        for (int k = 1; k < DIV_LAT; k++)
        begin
            st_next[k] = div_iter(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign quo = st_reg[DIV_LAT-1].quo;

endmodule

### design/prdg_sqrt.sv
module prdg_sqrt
    import prdg_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] value,
    output logic [31:0] root
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] bits;
    } sq_st_t;

    sq_st_t st_reg  [SQ_STAGES];
    sq_st_t st_next [SQ_STAGES];

    function automatic sq_st_t sq_iter(input sq_st_t s);
        sq_st_t      r;
        logic [35:0] acc;
        logic [35:0] trial;
        r = s;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            acc   = {r.rem, r.bits[63:62]};
            trial = {2'b00, r.root, 2'b01};
            if (acc >= trial)
            begin
                acc    = acc - trial;
                r.root = {r.root[30:0], 1'b1};
            end
            else
            begin
                r.root = {r.root[30:0], 1'b0};
            end
            r.rem  = acc[33:0];
            r.bits = {r.bits[61:0], 2'b00};
        end
        return r;
    endfunction

    always_comb
    begin
        sq_st_t init;
        init.rem   = '0;
        init.root  = '0;
        init.bits  = value;
        st_next[0] = sq_iter(init);
        for (int k = 1; k < SQ_STAGES; k++)
        begin
            st_next[k] = sq_iter(st_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign root = st_reg[SQ_STAGES-1].root;

endmodule

### design/primary_ray_direction_generator.sv
// Throughput: one pixel transaction per cycle while the output is not stalled;
// the rate is set by the fully pipelined dividers and square root. A load is
// taken only once no pixel is in flight; it gives no result.
// Reset: coefficients cleared, viewport 1 x 1, pipeline emptied.
module primary_ray_direction_generator
    import prdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    prdg_in_if.sink     pix_in,
    prdg_out_if.source  ray_out
);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] coef_reg [COEF_SLOTS];
    logic [5:0]  inflight_reg;

    logic en;
    logic in_acc;
    logic out_acc;
    logic px_acc;

    assign en      = !ray_out.valid || ray_out.ready;
    assign pix_in.ready = en && !(pix_in.cmd == CMD_LOAD && inflight_reg != 6'd0);
    assign in_acc  = pix_in.valid && pix_in.ready;
    assign px_acc  = in_acc && pix_in.cmd == CMD_PIXEL;
    assign out_acc = ray_out.valid && ray_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_SLOTS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (in_acc && pix_in.cmd == CMD_LOAD && pix_in.coef_index < 5'(COEF_SLOTS))
        begin
            coef_reg[pix_in.coef_index] <= pix_in.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 6'(px_acc) - 6'(out_acc);
        end
    end

    // ---------------- stage A: clamp
    logic [12:0] weff, heff;
    logic [11:0] xc, yc;
    side_t       side_a_reg, side_a_next;
    logic [11:0] x_a_reg, y_a_reg;
    logic [12:0] w_a_reg, h_a_reg;

    always_comb
    begin
        if (width_reg == 13'd0)
            weff = 13'd1;
        else if (width_reg > 13'(MAX_DIM))
            weff = 13'(MAX_DIM);
        else
            weff = width_reg;
        if (height_reg == 13'd0)
            heff = 13'd1;
        else if (height_reg > 13'(MAX_DIM))
            heff = 13'(MAX_DIM);
        else
            heff = height_reg;
        xc = ({1'b0, pix_in.pixel_x} > weff - 13'd1) ? 12'(weff - 13'd1) : pix_in.pixel_x;
        yc = ({1'b0, pix_in.pixel_y} > heff - 13'd1) ? 12'(heff - 13'd1) : pix_in.pixel_y;
        side_a_next     = '0;
        side_a_next.vld = px_acc;
    end

    // ---------------- stage B: NDC numerators, linear index
    side_t              side_b_reg, side_b_next;
    logic [12:0]        nxm_b_reg, nym_b_reg;
    logic [12:0]        w_b_reg, h_b_reg;
    logic signed [14:0] numx, numy;

    always_comb
    begin
        numx = $signed({2'b00, x_a_reg, 1'b0}) - $signed({2'b00, w_a_reg});
        numy = $signed({2'b00, y_a_reg, 1'b0}) - $signed({2'b00, h_a_reg});
        side_b_next     = side_a_reg;
        side_b_next.nxn = numx < 0;
        side_b_next.nyn = numy < 0;
        side_b_next.pix = 24'(x_a_reg) + 24'(y_a_reg) * 24'(w_a_reg);
    end

    logic [30:0] qx, qy;

    prdg_div u_div_x (
        .clk (clk), .en (en),
        .num ({18'd0, nxm_b_reg}), .den ({20'd0, w_b_reg}), .quo (qx)
    );
    prdg_div u_div_y (
        .clk (clk), .en (en),
        .num ({18'd0, nym_b_reg}), .den ({20'd0, h_b_reg}), .quo (qy)
    );

    side_t sd1_reg [DIV_LAT];

    // ---------------- stage C: signed NDC
    side_t              side_c_reg;
    logic signed [31:0] cx_c_reg, cy_c_reg;

    // ---------------- stage D: projection products
    side_t              side_d_reg;
    logic signed [33:0] pj_d_reg [4][2];
    logic signed [32:0] pc_d_reg [4];
    logic signed [33:0] pj_next  [4][2];
    logic signed [32:0] pc_next  [4];

    always_comb
    begin
        logic signed [63:0] p0, p1;
        for (int r = 0; r < 4; r++)
        begin
            p0 = $signed(coef_reg[r*4]) * cx_c_reg;
            p1 = $signed(coef_reg[r*4+1]) * cy_c_reg;
            pj_next[r][0] = 34'(p0 >>> NDC_FRAC_BITS);
            pj_next[r][1] = 34'(p1 >>> NDC_FRAC_BITS);
            pc_next[r] = 33'($signed(coef_reg[r*4+2])) + 33'($signed(coef_reg[r*4+3]));
        end
    end

    // ---------------- stage E: t
    side_t              side_e_reg;
    logic signed [34:0] t_e_reg [4];

    // ---------------- stage F: magnitudes, signs
    side_t       side_f_reg, side_f_next;
    logic [33:0] mag_f_reg [3];
    logic [33:0] mag_f_next [3];

    always_comb
    begin
        side_f_next = side_e_reg;
        for (int c = 0; c < 3; c++)
        begin
            side_f_next.neg[c] = t_e_reg[c][34] ^ t_e_reg[3][34];
            mag_f_next[c] = t_e_reg[c][34] ? 34'(-t_e_reg[c]) : 34'(t_e_reg[c]);
        end
        side_f_next.deg = (t_e_reg[3] == 35'sd0) ||
                          ((mag_f_next[0] | mag_f_next[1] | mag_f_next[2]) == 34'd0);
    end

    // ---------------- stage G: leading one
    side_t       side_g_reg;
    logic [33:0] mag_g_reg [3];
    logic [5:0]  pos_g_reg, pos_next;
    logic [33:0] orv;

    always_comb
    begin
        orv      = mag_f_reg[0] | mag_f_reg[1] | mag_f_reg[2];
        pos_next = '0;
        for (int i = 0; i < 34; i++)
        begin
            if (orv[i])
                pos_next = 6'(i);
        end
    end

    // ---------------- stage H: normalise so the largest sits in [2^30, 2^31)
    side_t       side_h_reg;
    logic [30:0] mag_h_reg [3];
    logic [30:0] mag_h_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (pos_g_reg > 6'd30)
                mag_h_next[c] = 31'(mag_g_reg[c] >> (pos_g_reg - 6'd30));
            else
                mag_h_next[c] = 31'(mag_g_reg[c] << (6'd30 - pos_g_reg));
        end
    end

    // ---------------- stages I, J: sum of squares
    side_t       side_i_reg, side_j_reg;
    logic [30:0] mag_i_reg [3];
    logic [30:0] mag_j_reg [3];
    logic [61:0] sq_i_reg  [3];
    logic [63:0] sum_j_reg;
    logic [31:0] len;

    prdg_sqrt u_sqrt (
        .clk (clk), .en (en), .value (sum_j_reg), .root (len)
    );

    side_t       ssq_reg [SQ_STAGES];
    logic [30:0] msq_reg [SQ_STAGES][3];

    logic [30:0] qn [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_ndiv
        prdg_div u_div_n (
            .clk (clk), .en (en),
            .num (msq_reg[SQ_STAGES-1][c]), .den ({1'b0, len}), .quo (qn[c])
        );
    end

    side_t sd2_reg [DIV_LAT];

    // ---------------- stage L: signed unit vector
    side_t              side_l_reg;
    logic signed [31:0] n_l_reg [3];

    // ---------------- stage M: rotation products
    side_t              side_m_reg;
    logic signed [39:0] rp_m_reg  [3][3];
    logic signed [39:0] rp_next   [3][3];

    always_comb
    begin
        logic signed [63:0] p;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p = $signed(coef_reg[VIEW_BASE+r*3+c]) * n_l_reg[c];
                rp_next[r][c] = 40'(p >>> COEF_FRAC_BITS);
            end
        end
    end

    // ---------------- output stage: sum, saturate, zero if degenerate
    logic signed [31:0] dir_next [3];

    always_comb
    begin
        logic signed [41:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = 42'(rp_m_reg[r][0]) + 42'(rp_m_reg[r][1]) + 42'(rp_m_reg[r][2]);
            if (side_m_reg.deg)
                dir_next[r] = '0;
            else if (acc > 42'sd2147483647)
                dir_next[r] = 32'sh7fffffff;
            else if (acc < -42'sd2147483648)
                dir_next[r] = 32'sh80000000;
            else
                dir_next[r] = 32'(acc);
        end
    end

    logic out_vld_reg;

    // valid-carrying sideband
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg  <= '0;
            side_b_reg  <= '0;
            side_c_reg  <= '0;
            side_d_reg  <= '0;
            side_e_reg  <= '0;
            side_f_reg  <= '0;
            side_g_reg  <= '0;
            side_h_reg  <= '0;
            side_i_reg  <= '0;
            side_j_reg  <= '0;
            side_l_reg  <= '0;
            side_m_reg  <= '0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                sd1_reg[k] <= '0;
                sd2_reg[k] <= '0;
            end
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                ssq_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side_a_reg <= side_a_next;
            side_b_reg <= side_b_next;
            sd1_reg[0] <= side_b_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sd1_reg[k] <= sd1_reg[k-1];
                sd2_reg[k] <= sd2_reg[k-1];
            end
            side_c_reg <= sd1_reg[DIV_LAT-1];
            side_d_reg <= side_c_reg;
            side_e_reg <= side_d_reg;
            side_f_reg <= side_f_next;
            side_g_reg <= side_f_reg;
            side_h_reg <= side_g_reg;
            side_i_reg <= side_h_reg;
            side_j_reg <= side_i_reg;
            ssq_reg[0] <= side_j_reg;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                ssq_reg[k] <= ssq_reg[k-1];
            end
            sd2_reg[0]  <= ssq_reg[SQ_STAGES-1];
            side_l_reg  <= sd2_reg[DIV_LAT-1];
            side_m_reg  <= side_l_reg;
            out_vld_reg <= side_m_reg.vld;
        end
    end

    // data path
    logic signed [31:0] dir_reg [3];
    logic [23:0]        pix_reg;
    logic               deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg   <= xc;
            y_a_reg   <= yc;
            w_a_reg   <= weff;
            h_a_reg   <= heff;
            nxm_b_reg <= numx < 0 ? 13'(-numx) : 13'(numx);
            nym_b_reg <= numy < 0 ? 13'(-numy) : 13'(numy);
            w_b_reg   <= w_a_reg;
            h_b_reg   <= h_a_reg;
            cx_c_reg  <= sd1_reg[DIV_LAT-1].nxn ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            cy_c_reg  <= sd1_reg[DIV_LAT-1].nyn ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            for (int r = 0; r < 4; r++)
            begin
                pj_d_reg[r][0] <= pj_next[r][0];
                pj_d_reg[r][1] <= pj_next[r][1];
                pc_d_reg[r]    <= pc_next[r];
                t_e_reg[r]     <= 35'(pj_d_reg[r][0]) + 35'(pj_d_reg[r][1])
                                + 35'(pc_d_reg[r]);
            end
            pos_g_reg <= pos_next;
            for (int c = 0; c < 3; c++)
            begin
                mag_f_reg[c] <= mag_f_next[c];
                mag_g_reg[c] <= mag_f_reg[c];
                mag_h_reg[c] <= mag_h_next[c];
                mag_i_reg[c] <= mag_h_reg[c];
                sq_i_reg[c]  <= 62'(mag_h_reg[c]) * 62'(mag_h_reg[c]);
                mag_j_reg[c] <= mag_i_reg[c];
                msq_reg[0][c] <= mag_j_reg[c];
                for (int k = 1; k < SQ_STAGES; k++)
                begin
                    msq_reg[k][c] <= msq_reg[k-1][c];
                end
                n_l_reg[c] <= sd2_reg[DIV_LAT-1].neg[c] ? -$signed({1'b0, qn[c]})
                                                        : $signed({1'b0, qn[c]});
                for (int r = 0; r < 3; r++)
                begin
                    rp_m_reg[r][c] <= rp_next[r][c];
                end
                dir_reg[c] <= dir_next[c];
            end
            sum_j_reg <= 64'(sq_i_reg[0]) + 64'(sq_i_reg[1]) + 64'(sq_i_reg[2]);
            pix_reg   <= side_m_reg.pix;
            deg_reg   <= side_m_reg.deg;
        end
    end

    assign ray_out.valid       = out_vld_reg;
    assign ray_out.dir_x       = dir_reg[0];
    assign ray_out.dir_y       = dir_reg[1];
    assign ray_out.dir_z       = dir_reg[2];
    assign ray_out.pixel_index = pix_reg;
    assign ray_out.degenerate  = deg_reg;

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && pix_in.cmd == CMD_LOAD) |-> inflight_reg == 6'd0)
        else $error("load taken with pixels in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 6'd0) |-> !out_vld_reg)
        else $error("result with no pixel in flight");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && deg_reg) |->
        (dir_reg[0] == 32'sd0 && dir_reg[1] == 32'sd0 && dir_reg[2] == 32'sd0))
        else $error("degenerate result with non-zero direction");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !px_acc) |=> inflight_reg == $past(inflight_reg) - 6'd1)
        else $error("in-flight count out of step");

endmodule
